// ===== src/assert_macros.svh =====
// assertion helpers shared by the classifier modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LCA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define LCA_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== src/lca_pkg.sv =====
package lca_pkg;

  localparam int OP_W   = 2;
  localparam int CLS_W  = 4;
  localparam int POS_W  = 10;
  localparam int LBL_W  = 4;
  localparam int CNT_W  = 32;
  localparam int ACC_W  = 48;
  localparam int FRAC_W = 12;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  localparam logic [OP_W-1:0] OP_COEF = 2'd0;
  localparam logic [OP_W-1:0] OP_ICPT = 2'd1;
  localparam logic [OP_W-1:0] OP_FEAT = 2'd2;

  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_ICPT,
    KIND_FEAT
  } lca_kind_t;

  typedef struct packed {
    lca_kind_t        kind;
    logic [CLS_W-1:0] cls;
    logic [POS_W-1:0] pos;
    logic             pos_ok;
    logic [LBL_W-1:0] lbl;
    logic             last;
  } lca_req_t;

endpackage

// ===== src/linear_classifier_argmax.sv =====
// channel   direction  fields
// in_       input      op, class_index, feature_index, value, label, last
// out_      output     predicted_class, no_class, correct, good_count
//
// one request per cycle for loads and features while the queue is not held for a vector end;
// the coefficient memories are read as one word per class at the feature address
// a feature goes from the queue through the coefficient read and product registers into its accumulator
// a last feature starts scoring of all NUM_CLASSES classes, one class per cycle unless a stalled result holds it
// reset clears queue, accumulators, counter and output valid; stores are unset
// out_stall holds the result register; the queue stalls in_ when full
module linear_classifier_argmax #(
  parameter int NUM_CLASSES  = 10,
  parameter int MAX_FEATURES = 1024,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lca_pkg::OP_W-1:0]      in_op,
  input  logic [lca_pkg::CLS_W-1:0]     in_class_index,
  input  logic [lca_pkg::POS_W-1:0]     in_feature_index,
  input  logic signed [DATA_WIDTH-1:0]  in_value,
  input  logic [lca_pkg::LBL_W-1:0]     in_label,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lca_pkg::CLS_W-1:0]     out_predicted_class,
  output logic                          out_no_class,
  output logic                          out_correct,
  output logic [lca_pkg::CNT_W-1:0]     out_good_count
);
  import lca_pkg::*;

  logic                         q_valid;
  logic                         q_pop;
  lca_req_t                     q_req;
  logic signed [DATA_WIDTH-1:0] q_val;

  lca_front #(
    .NUM_CLASSES  (NUM_CLASSES),
    .MAX_FEATURES (MAX_FEATURES),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_class_index   (in_class_index),
    .in_feature_index (in_feature_index),
    .in_value         (in_value),
    .in_label         (in_label),
    .in_last          (in_last),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_req            (q_req),
    .q_val            (q_val)
  );

  lca_back #(
    .NUM_CLASSES  (NUM_CLASSES),
    .MAX_FEATURES (MAX_FEATURES),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_req               (q_req),
    .q_val               (q_val),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_class (out_predicted_class),
    .out_no_class        (out_no_class),
    .out_correct         (out_correct),
    .out_good_count      (out_good_count)
  );

endmodule

// ===== src/lca_front.sv =====
`include "assert_macros.svh"

module lca_front #(
  parameter int NUM_CLASSES  = 10,
  parameter int MAX_FEATURES = 1024,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lca_pkg::OP_W-1:0]      in_op,
  input  logic [lca_pkg::CLS_W-1:0]     in_class_index,
  input  logic [lca_pkg::POS_W-1:0]     in_feature_index,
  input  logic signed [DATA_WIDTH-1:0]  in_value,
  input  logic [lca_pkg::LBL_W-1:0]     in_label,
  input  logic                          in_last,
  output logic                          q_valid,
  input  logic                          q_pop,
  output lca_pkg::lca_req_t             q_req,
  output logic signed [DATA_WIDTH-1:0]  q_val
);
  import lca_pkg::*;

  lca_req_t                req;
  logic                    keep;
  logic                    push;
  lca_req_t                fifo_req_r [QDEPTH];
  logic [DATA_WIDTH-1:0]   fifo_val_r [QDEPTH];
  logic [QPW-1:0]          wr_ptr_r;
  logic [QPW-1:0]          rd_ptr_r;
  logic [QPW:0]            cnt_r;
  logic [QPW:0]            cnt_nxt;
  logic                    cls_ok;
  logic                    pos_ok;

  assign cls_ok = 32'(in_class_index) < 32'(NUM_CLASSES);
  assign pos_ok = 32'(in_feature_index) < 32'(MAX_FEATURES);

  // decode the request and drop the ones that change nothing
  always_comb begin
    req.cls    = in_class_index;
    req.pos    = in_feature_index;
    req.pos_ok = pos_ok;
    req.lbl    = in_label;
    req.last   = in_last;
    req.kind   = KIND_FEAT;
    keep       = 1'b0;
    case (in_op)
      OP_COEF: begin
        req.kind = KIND_COEF;
        keep     = cls_ok & pos_ok;
      end
      OP_ICPT: begin
        req.kind = KIND_ICPT;
        keep     = cls_ok;
      end
      OP_FEAT: begin
        req.kind = KIND_FEAT;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt_r == (QPW+1)'(QDEPTH));
  assign push     = in_valid & ~in_stall & keep;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = fifo_req_r[rd_ptr_r];
  assign q_val    = fifo_val_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_req_r[wr_ptr_r] <= req;
      fifo_val_r[wr_ptr_r] <= in_value;
    end
  end

  `LCA_NEVER(a_q_overflow, cnt_r > (QPW+1)'(QDEPTH), "request queue count beyond depth")
  `LCA_NEVER(a_q_pop_empty, q_pop && !q_valid, "pop from empty request queue")
  `LCA_ASSERT(a_q_hold, q_valid && !q_pop |=> q_valid && $stable(q_req), "queue head changed")

endmodule

// ===== src/lca_back.sv =====
`include "assert_macros.svh"

module lca_back #(
  parameter int NUM_CLASSES  = 10,
  parameter int MAX_FEATURES = 1024,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  lca_pkg::lca_req_t             q_req,
  input  logic signed [DATA_WIDTH-1:0]  q_val,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lca_pkg::CLS_W-1:0]     out_predicted_class,
  output logic                          out_no_class,
  output logic                          out_correct,
  output logic [lca_pkg::CNT_W-1:0]     out_good_count
);
  import lca_pkg::*;

  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PW = 2 * DATA_WIDTH;

  logic                         busy;
  logic                         is_feat;
  logic [FA-1:0]                addr;
  logic signed [DATA_WIDTH-1:0] rd_r [NUM_CLASSES];

  logic                         s1_vld_r, s1_last_r, s1_ok_r;
  logic signed [DATA_WIDTH-1:0] s1_val_r;
  logic [LBL_W-1:0]             s1_lbl_r;
  logic                         s2_vld_r, s2_last_r, s2_ok_r;
  logic [LBL_W-1:0]             s2_lbl_r;
  logic signed [PW-1:0]         prod_r [NUM_CLASSES];
  logic signed [ACC_W-1:0]      acc_r [NUM_CLASSES];
  logic signed [DATA_WIDTH-1:0] icpt_r [NUM_CLASSES];

  logic                         scan_r;
  logic [CW-1:0]                idx_r;
  logic signed [ACC_W-1:0]      best_r;
  logic [CW-1:0]                bidx_r;
  logic                         found_r;
  logic [LBL_W-1:0]             lbl_r;
  logic signed [ACC_W-1:0]      bias;
  logic signed [ACC_W-1:0]      score;
  logic                         better;
  logic                         at_end;
  logic                         step;
  logic                         fin;
  logic                         fin_found;
  logic [CW-1:0]                fin_idx;
  logic                         hit;

  logic                         out_valid_r;
  logic [CLS_W-1:0]             out_cls_r;
  logic                         out_none_r;
  logic                         out_hit_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_nxt;

  // hold the queue while a vector end is in flight or being scored
  assign busy    = scan_r | (s1_vld_r & s1_last_r) | (s2_vld_r & s2_last_r);
  assign q_pop   = q_valid & ~busy;
  assign is_feat = (q_req.kind == KIND_FEAT);
  assign addr    = FA'(q_req.pos);

  // one coefficient memory per class, all read at the same feature address
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cls
    logic [DATA_WIDTH-1:0] mem [MAX_FEATURES];
    logic                  we;

    assign we = q_pop && (q_req.kind == KIND_COEF) && (q_req.cls == CLS_W'(c));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[addr] <= q_val;
      end
      if (q_pop && is_feat) begin
        rd_r[c] <= mem[addr];
      end
    end

    always_ff @(posedge clk) begin
      prod_r[c] <= s1_val_r * rd_r[c];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[c] <= '0;
      end else if (fin) begin
        acc_r[c] <= '0;
      end else if (s2_vld_r && s2_ok_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_req.kind == KIND_ICPT)) begin
      icpt_r[q_req.cls[CW-1:0]] <= q_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= q_pop & is_feat;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= q_req.last;
    s1_ok_r   <= q_req.pos_ok;
    s1_val_r  <= q_val;
    s1_lbl_r  <= q_req.lbl;
    s2_last_r <= s1_last_r;
    s2_ok_r   <= s1_ok_r;
    s2_lbl_r  <= s1_lbl_r;
  end

  // scores one class per cycle unless stalled; intercept at product point
  assign bias   = ACC_W'(icpt_r[idx_r]) <<< FRAC_W;
  assign score  = acc_r[idx_r] + bias;
  assign better = score > best_r;
  assign at_end = (idx_r == CW'(NUM_CLASSES - 1));
  assign step   = scan_r & (~at_end | ~out_valid_r | ~out_stall);
  assign fin    = step & at_end;

  assign fin_found = found_r | better;
  assign fin_idx   = better ? idx_r : bidx_r;
  assign hit       = fin_found && (CLS_W'(fin_idx) == lbl_r);
  assign cnt_nxt   = hit ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
    end else if (s2_vld_r && s2_last_r) begin
      scan_r <= 1'b1;
    end else if (fin) begin
      scan_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_last_r) begin
      idx_r   <= '0;
      best_r  <= '0;
      bidx_r  <= '0;
      found_r <= 1'b0;
      lbl_r   <= s2_lbl_r;
    end else if (step) begin
      if (better) begin
        best_r  <= score;
        bidx_r  <= idx_r;
        found_r <= 1'b1;
      end
      if (!at_end) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (fin) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_cls_r  <= fin_found ? CLS_W'(fin_idx) : '0;
      out_none_r <= ~fin_found;
      out_hit_r  <= hit;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_cls_r;
  assign out_no_class        = out_none_r;
  assign out_correct         = out_hit_r;
  assign out_good_count      = cnt_r;

  `LCA_NEVER(a_pop_in_scan, q_pop && scan_r, "request taken while scoring")
  `LCA_ASSERT(a_scan_start, $rose(scan_r) |-> $past(s2_vld_r && s2_last_r), "scan without vector end")
  `LCA_ASSERT(a_fin_free, fin |-> (!out_valid_r || !out_stall), "result overwritten while stalled")
  `LCA_NEVER(a_pipe_in_scan, scan_r && (s1_vld_r || s2_vld_r), "feature in pipe during scoring")

endmodule
